@@ design/assert_macros.svh @@
// Assertion macros used by the timer deadline top-level design file.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tdc_pkg.sv @@
// Package for the timer deadline to compare value block.
// Holds register indexes, field widths and pipeline constants; no dependencies.
package tdc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BOOT_COUNT   = 3'd0,
        CFG_NS_MULT      = 3'd1,
        CFG_NS_SHIFT     = 3'd2,
        CFG_TICK_MULT    = 3'd3,
        CFG_TICK_SHIFT   = 3'd4,
        CFG_WHOLE_NS     = 3'd5,
        CFG_TICK_LIMIT   = 3'd6
    } cfg_index_t;

    localparam int WORD_W  = 64;
    localparam int MULT_W  = 32;
    localparam int SHIFT_W = 6;
    localparam int WHOLE_W = 30;

    // Deadlines further away than one hour use the division path
    localparam logic [WORD_W-1:0] LONG_RANGE_NS = 64'd3600000000000;

    // One quotient bit per divider stage
    localparam int DIV_STAGES = WORD_W;

    typedef logic [WORD_W-1:0] word_t;

endpackage

@@ design/timer_deadline_to_compare_value.sv @@
// Top level of the timer deadline to compare value block.
// Depends on tdc_pkg and assert_macros.svh.
//
// Usage:
//   The input channel (in_valid/in_stall) carries one beat per request: a raw
//   counter reading and a deadline in ns since boot. The output channel
//   (out_valid/out_stall) returns one beat per request: now_ns, the compare
//   value, timer_armed and deadline_passed, in request order.
//   Configuration is written through cfg_write_en/cfg_index/cfg_data while
//   no request is in flight.
// Pipeline: ten stages for the elapsed time, ns conversion, compare and
//   tick conversion, 64 divider stages (one quotient bit each) and the
//   output register.
// Throughput: one beat per cycle unless the output is held. Both conversions
//   use 32x32 partial products and the divider is fully unrolled into stages.
// Reset: all valid bits clear and the configuration registers take their
//   reset values; the pipeline is empty and the block accepts a beat at once.
// Stall: when the output beat is held, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
module timer_deadline_to_compare_value (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [tdc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tdc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [63:0]                   counter_value,
    input  logic [63:0]                   deadline_ns,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [63:0]                   now_ns,
    output logic [63:0]                   compare_value,
    output logic                          timer_armed,
    output logic                          deadline_passed
);
    import tdc_pkg::*;
    `include "assert_macros.svh"

    // Configuration registers
    word_t               boot_count_reg;
    logic [MULT_W-1:0]   ns_mult_reg;
    logic [SHIFT_W-1:0]  ns_shift_reg;
    logic [MULT_W-1:0]   tick_mult_reg;
    logic [SHIFT_W-1:0]  tick_shift_reg;
    logic [WHOLE_W-1:0]  whole_ns_reg;
    word_t               tick_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_count_reg <= '0;
            ns_mult_reg    <= MULT_W'(1);
            ns_shift_reg   <= '0;
            tick_mult_reg  <= MULT_W'(1);
            tick_shift_reg <= '0;
            whole_ns_reg   <= WHOLE_W'(1);
            tick_limit_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BOOT_COUNT: boot_count_reg <= cfg_data;
                CFG_NS_MULT:    ns_mult_reg    <= cfg_data[MULT_W-1:0];
                CFG_NS_SHIFT:   ns_shift_reg   <= cfg_data[SHIFT_W-1:0];
                CFG_TICK_MULT:  tick_mult_reg  <= cfg_data[MULT_W-1:0];
                CFG_TICK_SHIFT: tick_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_WHOLE_NS:   whole_ns_reg   <= cfg_data[WHOLE_W-1:0];
                CFG_TICK_LIMIT: tick_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances unless the output beat is held
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Valid bits of stages 1..10
    logic [10:1] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[9:1], in_valid};
    end

    // Payload of stages 1..10
    word_t cnt1_reg, dl1_reg, el1_reg;
    word_t cnt2_reg, dl2_reg, el2_reg;
    logic  long2_reg;
    word_t cnt3_reg, dl3_reg, pl3_reg;
    logic [MULT_W-1:0] ph3_reg;
    logic  long3_reg;
    word_t cnt4_reg, dl4_reg, prod4_reg;
    logic  long4_reg;
    word_t cnt5_reg, dl5_reg, now5_reg;
    word_t cnt6_reg, now6_reg, rem6_reg;
    logic  arm6_reg;
    word_t cnt7_reg, now7_reg, rem7_reg;
    logic  arm7_reg, big7_reg;
    word_t cnt8_reg, now8_reg, rem8_reg, tl8_reg;
    logic [MULT_W-1:0] th8_reg;
    logic  arm8_reg, big8_reg;
    word_t cnt9_reg, now9_reg, rem9_reg, tp9_reg;
    logic  arm9_reg, big9_reg;
    word_t cnt10_reg, now10_reg, rem10_reg, ts10_reg;
    logic  arm10_reg, big10_reg;

    logic [MULT_W-1:0] ns_mult_sel;
    assign ns_mult_sel = long2_reg ? MULT_W'(whole_ns_reg) : ns_mult_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Elapsed ticks since boot
            cnt1_reg  <= counter_value;
            dl1_reg   <= deadline_ns;
            el1_reg   <= counter_value - boot_count_reg;
            // Pick the conversion path
            cnt2_reg  <= cnt1_reg;
            dl2_reg   <= dl1_reg;
            el2_reg   <= el1_reg;
            long2_reg <= el1_reg > tick_limit_reg;
            // Partial products of ticks to ns
            cnt3_reg  <= cnt2_reg;
            dl3_reg   <= dl2_reg;
            long3_reg <= long2_reg;
            pl3_reg   <= WORD_W'(ns_mult_sel) * WORD_W'(el2_reg[MULT_W-1:0]);
            ph3_reg   <= ns_mult_sel * el2_reg[WORD_W-1:MULT_W];
            // Sum partial products
            cnt4_reg  <= cnt3_reg;
            dl4_reg   <= dl3_reg;
            long4_reg <= long3_reg;
            prod4_reg <= pl3_reg + {ph3_reg, {MULT_W{1'b0}}};
            // Scale to ns
            cnt5_reg  <= cnt4_reg;
            dl5_reg   <= dl4_reg;
            now5_reg  <= long4_reg ? prod4_reg : (prod4_reg >> ns_shift_reg);
            // Compare against the deadline
            cnt6_reg  <= cnt5_reg;
            now6_reg  <= now5_reg;
            arm6_reg  <= now5_reg < dl5_reg;
            rem6_reg  <= dl5_reg - now5_reg;
            // Long range check
            cnt7_reg  <= cnt6_reg;
            now7_reg  <= now6_reg;
            arm7_reg  <= arm6_reg;
            rem7_reg  <= rem6_reg;
            big7_reg  <= rem6_reg > LONG_RANGE_NS;
            // Partial products of ns to ticks
            cnt8_reg  <= cnt7_reg;
            now8_reg  <= now7_reg;
            arm8_reg  <= arm7_reg;
            big8_reg  <= big7_reg;
            rem8_reg  <= rem7_reg;
            tl8_reg   <= WORD_W'(tick_mult_reg) * WORD_W'(rem7_reg[MULT_W-1:0]);
            th8_reg   <= tick_mult_reg * rem7_reg[WORD_W-1:MULT_W];
            // Sum partial products
            cnt9_reg  <= cnt8_reg;
            now9_reg  <= now8_reg;
            arm9_reg  <= arm8_reg;
            big9_reg  <= big8_reg;
            rem9_reg  <= rem8_reg;
            tp9_reg   <= tl8_reg + {th8_reg, {MULT_W{1'b0}}};
            // Scale to ticks
            cnt10_reg <= cnt9_reg;
            now10_reg <= now9_reg;
            arm10_reg <= arm9_reg;
            big10_reg <= big9_reg;
            rem10_reg <= rem9_reg;
            ts10_reg  <= tp9_reg >> tick_shift_reg;
        end
    end

    // Divider: one restoring step per stage, entry 0 is fed from stage 10
    logic                dv_reg   [DIV_STAGES+1];
    word_t               dq_reg   [DIV_STAGES+1];
    logic [WHOLE_W-1:0]  dr_reg   [DIV_STAGES+1];
    word_t               dcnt_reg [DIV_STAGES+1];
    word_t               dnow_reg [DIV_STAGES+1];
    word_t               dts_reg  [DIV_STAGES+1];
    logic                darm_reg [DIV_STAGES+1];
    logic                dbig_reg [DIV_STAGES+1];

    assign dv_reg[0]   = v_reg[10];
    assign dq_reg[0]   = rem10_reg;
    assign dr_reg[0]   = '0;
    assign dcnt_reg[0] = cnt10_reg;
    assign dnow_reg[0] = now10_reg;
    assign dts_reg[0]  = ts10_reg;
    assign darm_reg[0] = arm10_reg;
    assign dbig_reg[0] = big10_reg;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [WHOLE_W:0]   trial;
        logic               ge;
        logic [WHOLE_W:0]   diff;
        logic [WHOLE_W-1:0] rem_next;

        assign trial    = {dr_reg[k], dq_reg[k][WORD_W-1]};
        assign ge       = trial >= {1'b0, whole_ns_reg};
        assign diff     = trial - {1'b0, whole_ns_reg};
        assign rem_next = ge ? diff[WHOLE_W-1:0] : trial[WHOLE_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (adv)
                dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dr_reg[k+1]   <= rem_next;
                dq_reg[k+1]   <= {dq_reg[k][WORD_W-2:0], ge};
                dcnt_reg[k+1] <= dcnt_reg[k];
                dnow_reg[k+1] <= dnow_reg[k];
                dts_reg[k+1]  <= dts_reg[k];
                darm_reg[k+1] <= darm_reg[k];
                dbig_reg[k+1] <= dbig_reg[k];
            end
        end
    end

    // Output register: pick the tick count and form the compare value
    word_t ticks_sel;
    word_t now_reg, cmp_reg;
    logic  armed_reg;
    assign ticks_sel = dbig_reg[DIV_STAGES] ? dq_reg[DIV_STAGES] : dts_reg[DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            now_reg   <= dnow_reg[DIV_STAGES];
            armed_reg <= darm_reg[DIV_STAGES];
            cmp_reg   <= darm_reg[DIV_STAGES] ? dcnt_reg[DIV_STAGES] + ticks_sel : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign now_ns          = now_reg;
    assign compare_value   = cmp_reg;
    assign timer_armed     = armed_reg;
    assign deadline_passed = !armed_reg;

    // Checks
    `TDC_ASSERT_NOW(a_idle_cmp_zero, out_valid_reg && !armed_reg, cmp_reg == '0,
        "compare value not zero for passed deadline")
    `TDC_ASSERT_NOW(a_stall_rule, 1'b1, in_stall == (out_valid_reg && out_stall),
        "input stall does not follow held output")
    `TDC_ASSERT_NEXT(a_div_entry, adv && v_reg[10], dv_reg[1],
        "beat lost entering divider")
    `TDC_ASSERT_NEXT(a_hold_out, out_valid_reg && out_stall,
        out_valid_reg && $stable(cmp_reg) && $stable(now_reg),
        "held result changed")

endmodule
